// ===== hdl/nfa_byte_matcher_macros.svh =====
// Assertion macros used by the matcher checker.
`ifndef NFA_BYTE_MATCHER_MACROS_SVH
`define NFA_BYTE_MATCHER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NBM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/nbm_pkg.sv =====
// Shared field widths, function codes and record types of the NFA byte matcher.
`default_nettype none

package nbm_pkg;

  localparam int FUNC_W   = 3;
  localparam int STATE_W  = 6;
  localparam int LETTER_W = 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR = 3'd0,
    FN_ADD   = 3'd1,
    FN_START = 3'd2,
    FN_BYTE  = 3'd3,
    FN_END   = 3'd4
  } func_e;

  typedef struct packed {
    logic [STATE_W-1:0]  from_state;
    logic [LETTER_W-1:0] letter;
    logic [STATE_W-1:0]  to_state;
  } trans_entry_t;

  typedef struct packed {
    logic verdict_valid;
    logic accepted;
    logic any_active;
    logic table_full;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/nfa_byte_matcher.sv =====
// Top level of the NFA byte matcher: transition table memory and state-set scan engine.
//
// The matcher keeps up to MAX_TRANS transitions in a single-port-read table memory and
// the active state set as a NUM_STATES-bit vector. Clear, add, start, end-of-input and
// unused codes are accepted in idle and then go to the result state. An input byte goes
// through the scan state first: the engine reads one table entry per cycle through the
// memory's one read port, folds each matching entry into the next state set, then
// commits that set. A new transaction is taken whenever the engine is idle, even while
// the previous result still waits in the output register. The table needs no clearing
// pass after reset; only entries below the fill count are ever read.
`default_nettype none

module nfa_byte_matcher
  import nbm_pkg::*;
#(
  parameter int NUM_STATES = 64,
  parameter int MAX_TRANS  = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [FUNC_W-1:0]   func_i,
  input  wire logic [STATE_W-1:0]  from_state_i,
  input  wire logic [LETTER_W-1:0] letter_i,
  input  wire logic [STATE_W-1:0]  to_state_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     verdict_valid_o,
  output logic                     accepted_o,
  output logic                     any_active_o,
  output logic                     table_full_o
);

  localparam int CNT_W  = $clog2(MAX_TRANS + 1);
  localparam int AW     = (MAX_TRANS > 1) ? $clog2(MAX_TRANS) : 1;
  localparam int SIDX_W = $clog2(NUM_STATES);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_TRANS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_e;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      ptr_q, ptr_d;
  logic [NUM_STATES-1:0] active_q, active_d;
  logic [NUM_STATES-1:0] next_q, next_d;
  logic [LETTER_W-1:0]   letter_q, letter_d;
  logic                  rd_vld_q, rd_vld_d;
  result_t               res_q, res_d;
  result_t               out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  trans_entry_t          table_mem [MAX_TRANS];
  trans_entry_t          rd_data_q;
  trans_entry_t          wr_entry;
  logic                  wr_en;
  logic                  rd_en;

  logic                  from_ok;
  logic                  to_ok;
  logic [SIDX_W-1:0]     from_idx;
  logic [SIDX_W-1:0]     src_idx;
  logic [SIDX_W-1:0]     dst_idx;
  logic                  hit;

  assign from_ok  = 32'(from_state_i) < NUM_STATES;
  assign to_ok    = 32'(to_state_i) < NUM_STATES;
  assign from_idx = SIDX_W'(from_state_i);
  assign src_idx  = SIDX_W'(rd_data_q.from_state);
  assign dst_idx  = SIDX_W'(rd_data_q.to_state);
  assign hit      = rd_vld_q && (rd_data_q.letter == letter_q) && active_q[src_idx];

  assign wr_entry = '{from_state: from_state_i, letter: letter_i, to_state: to_state_i};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    active_d    = active_q;
    next_d      = next_q;
    letter_d    = letter_q;
    rd_vld_d    = 1'b0;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          res_d   = '{verdict_valid: 1'b0, accepted: 1'b0, any_active: |active_q,
                      table_full: 1'b0};
          state_d = ST_RESULT;
          unique case (func_i)
            FN_CLEAR: begin
              count_d = '0;
            end
            FN_ADD: begin
              if (count_q == CNT_FULL) begin
                res_d.table_full = 1'b1;
              end else if (from_ok && to_ok) begin
                wr_en   = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
            FN_START: begin
              active_d = '0;
              if (from_ok) begin
                active_d[from_idx] = 1'b1;
              end
              res_d.any_active = from_ok;
            end
            FN_BYTE: begin
              letter_d = letter_i;
              next_d   = '0;
              ptr_d    = '0;
              state_d  = ST_SCAN;
            end
            FN_END: begin
              res_d.verdict_valid = 1'b1;
              res_d.accepted      = active_q[0];
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (ptr_q != count_q) begin
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          ptr_d    = ptr_q + CNT_W'(1);
        end
        if (hit) begin
          next_d[dst_idx] = 1'b1;
        end
        if ((ptr_q == count_q) && !rd_vld_q) begin
          active_d         = next_q;
          res_d.any_active = |next_q;
          state_d          = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_d) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ptr_q       <= '0;
      active_q    <= '0;
      next_q      <= '0;
      letter_q    <= '0;
      rd_vld_q    <= 1'b0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      active_q    <= active_d;
      next_q      <= next_d;
      letter_q    <= letter_d;
      rd_vld_q    <= rd_vld_d;
      res_q       <= res_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[count_q[AW-1:0]] <= wr_entry;
    end
    if (rd_en) begin
      rd_data_q <= table_mem[ptr_q[AW-1:0]];
    end
  end

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign verdict_valid_o = out_q.verdict_valid;
  assign accepted_o      = out_q.accepted;
  assign any_active_o    = out_q.any_active;
  assign table_full_o    = out_q.table_full;

endmodule

`default_nettype wire

// ===== hdl/nbm_checker.sv =====
// Port-level checker of the NFA byte matcher and its bind to the top level.
`default_nettype none

`include "nfa_byte_matcher_macros.svh"

module nbm_checker
  import nbm_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic [FUNC_W-1:0]   func_i,
  input wire logic [STATE_W-1:0]  from_state_i,
  input wire logic [LETTER_W-1:0] letter_i,
  input wire logic [STATE_W-1:0]  to_state_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire logic                verdict_valid_o,
  input wire logic                accepted_o,
  input wire logic                any_active_o,
  input wire logic                table_full_o
);

  logic out_hold;
  logic in_xact;

  assign out_hold = out_valid_o && !out_ready_i;
  assign in_xact  = in_valid_i && in_ready_o;

  `NBM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_hold,
    out_valid_o && $stable({verdict_valid_o, accepted_o, any_active_o, table_full_o}),
    "result changed while stalled")
  `NBM_ASSERT_SAME(a_accept_needs_verdict, clk_i, rst_ni, out_valid_o && accepted_o,
    verdict_valid_o, "accepted without end-of-input verdict")
  `NBM_ASSERT_SAME(a_accept_needs_active, clk_i, rst_ni, out_valid_o && accepted_o,
    any_active_o, "accepted with empty active set")
  `NBM_ASSERT_SAME(a_full_not_verdict, clk_i, rst_ni, out_valid_o && table_full_o,
    !verdict_valid_o, "table full flagged on end of input")
  `NBM_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_xact, !in_ready_o,
    "second transaction taken while busy")

endmodule

bind nfa_byte_matcher nbm_checker u_nbm_checker (.*);

`default_nettype wire
